// ===== rtl/ovl_pkg.sv =====
// Shared types, constants and helpers for the ordered value list.
package ovl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_FIND      = 3'd3,
    OP_POP       = 3'd4,
    OP_PEEK      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FRONT,
    S_DONE
  } state_t;

  // write and read port controls for the entry store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } rsp_t;

  // slot of a logical position: front plus position, wrapped at CAPACITY
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = {1'b0, pos} + (CNT_W+1)'(front);
    if (s >= (CNT_W+1)'(CAPACITY)) s = s - (CNT_W+1)'(CAPACITY);
    // past-the-end lookahead reads may wrap twice; keep them in range
    if (s >= (CNT_W+1)'(CAPACITY)) s = s - (CNT_W+1)'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/ovl_if.sv =====
// Request and response channel interfaces.
interface ovl_req_if;
  logic                            valid;
  logic                            ready;
  logic [ovl_pkg::OP_W-1:0]        op;
  logic signed [ovl_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface ovl_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ovl_pkg::STAT_W-1:0]       status;
  logic signed [ovl_pkg::VAL_W-1:0] result_value;
  logic [ovl_pkg::CNT_W-1:0]        entry_count;

  modport source (output valid, output status, output result_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input entry_count,
                  output ready);
endinterface

// ===== rtl/ovl_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module ovl_mem (
  input  logic                       clk,
  input  ovl_pkg::mem_req_t          req,
  output logic [ovl_pkg::VAL_W-1:0]  rdata
);
  import ovl_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/ovl_ctrl.sv =====
// Sequencer: walks the ring one slot a cycle with a single comparator.
module ovl_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  ovl_req_if.sink                   req,
  input  logic [ovl_pkg::VAL_W-1:0] rdata,
  input  logic                      out_free,
  output ovl_pkg::mem_req_t         mem,
  output logic                      done,
  output ovl_pkg::rsp_t             rsp
);
  import ovl_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  op_t              op_r, op_r_next;
  logic [VAL_W-1:0] value_r, value_r_next;
  status_t          res_status, res_status_next;
  logic [VAL_W-1:0] res_value, res_value_next;

  logic             full, empty, hit, last;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W-1:0] front_dec;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign hit       = (rdata == value_r);
  assign pos_inc   = pos + 1'b1;
  assign last      = (pos_inc == count);
  assign front_dec = (front == '0) ? IDX_W'(CAPACITY - 1) : front - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    op_r       <= op_r_next;
    value_r    <= value_r_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.op))
            OP_REMOVE, OP_FIND: state_next = empty ? S_DONE : S_SEARCH;
            OP_POP, OP_PEEK:    state_next = empty ? S_DONE : S_FRONT;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) state_next = (op_r == OP_REMOVE) ? S_SHIFT : S_DONE;
        else if (last) state_next = S_DONE;
      end
      S_SHIFT: begin
        if (pos == count) state_next = S_DONE;
      end
      S_FRONT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and port controls
  always_comb begin
    mem.we          = 1'b0;
    mem.waddr       = slot_of(front, count);
    mem.wdata       = value_r;
    mem.raddr       = front;
    req.ready       = 1'b0;
    done            = 1'b0;
    front_next      = front;
    count_next      = count;
    pos_next        = pos;
    op_r_next       = op_r;
    value_r_next    = value_r;
    res_status_next = res_status;
    res_value_next  = res_value;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_r_next       = op_t'(req.op);
          value_r_next    = req.value;
          pos_next        = '0;
          res_status_next = ST_MISS;
          res_value_next  = '1;
          case (op_t'(req.op))
            OP_INS_FRONT, OP_INS_BACK: begin
              res_value_next = '0;
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                res_status_next = ST_OK;
                mem.we          = 1'b1;
                mem.wdata       = req.value;
                count_next      = count + 1'b1;
                if (op_t'(req.op) == OP_INS_FRONT) begin
                  mem.waddr  = front_dec;
                  front_next = front_dec;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        // rdata holds position pos; fetch pos+1 ahead
        mem.raddr = slot_of(front, pos_inc);
        if (hit) begin
          res_status_next = ST_OK;
          res_value_next  = rdata;
          pos_next        = pos_inc;
        end else if (!last) begin
          pos_next = pos_inc;
        end
      end
      S_SHIFT: begin
        // move entry at pos one place toward the front
        mem.raddr = slot_of(front, pos_inc);
        if (pos == count) begin
          count_next = count - 1'b1;
        end else begin
          mem.we    = 1'b1;
          mem.waddr = slot_of(front, pos - 1'b1);
          mem.wdata = rdata;
          pos_next  = pos_inc;
        end
      end
      S_FRONT: begin
        res_status_next = ST_OK;
        res_value_next  = rdata;
        if (op_r == OP_POP) begin
          front_next = slot_of(front, CNT_W'(1));
          count_next = count - 1'b1;
        end
      end
      S_DONE: done = out_free;
      default: ;
    endcase
  end

  assign rsp.status = res_status;
  assign rsp.value  = res_value;
  assign rsp.count  = count;

endmodule

// ===== rtl/ordered_value_list.sv =====
// Top level of the ordered value list: store, sequencer and response register.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-----------------------------------------
//  req     | in  | valid/ready  | op[2:0], value[31:0] signed
//  rsp     | out | valid/ready  | status[1:0], result_value[31:0], entry_count[4:0]
//
// Work per item, from one accept to the next with the output free:
//   insert: written in the accept cycle. pop, peek: one store read. empty list or unused op: none.
//   find: walks from the front until a match or the end of the list.
//   remove: walks to the match, then closes the gap behind it.
//   The longest items are set by the single store read port.
// Reset clears the count, the front pointer and the sequencer; entries are
// not cleared, only data from live slots is ever used.
// The response sits in its own register, so a stalled consumer holds only the
// next result; req ready stays low while one item is in flight.
module ordered_value_list_unit (
  input logic      clk,
  input logic      rst,
  ovl_req_if.sink  req,
  ovl_rsp_if.source rsp
);
  import ovl_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;
  logic             done;
  logic             out_free;
  rsp_t             result;

  logic             out_valid;
  rsp_t             out_data;

  ovl_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  ovl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rdata    (rdata),
    .out_free (out_free),
    .mem      (mem_req),
    .done     (done),
    .rsp      (result)
  );

  // response register; a new result may replace one taken in the same cycle
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.result_value = out_data.value;
  assign rsp.entry_count  = out_data.count;

endmodule

// ===== rtl/ovl_checker.sv =====
// Port-level checks for the ordered value list, bound to the top level.
module ovl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [ovl_pkg::STAT_W-1:0]  status,
  input logic [ovl_pkg::VAL_W-1:0]   result_value,
  input logic [ovl_pkg::CNT_W-1:0]   entry_count
);
  import ovl_pkg::*;

  // one item in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(result_value) && $stable(entry_count))
    else $error("stalled response changed");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_MISS |-> result_value == '1)
    else $error("miss without all-ones value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

endmodule

bind ordered_value_list_unit ovl_checker u_ovl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .result_value (rsp.result_value),
  .entry_count  (rsp.entry_count)
);
